@@ hdl/tpcp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpcp_pkg;

  localparam int unsigned LongPressW = 16;
  localparam int unsigned StepW      = 7;
  localparam int unsigned LevelW     = 8;
  localparam int unsigned FactorW    = 8;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned EffectW    = 3;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0]    CFG_LONG_PRESS_MS   = 1'd0;
  localparam logic [CfgIdxW-1:0]    CFG_BRIGHTNESS_STEP = 1'd1;

  localparam logic [LongPressW-1:0] LONG_PRESS_RST = 16'd500;
  localparam logic [StepW-1:0]      STEP_RST       = 7'd25;
  localparam logic [LevelW-1:0]     LEVEL_MAX      = 8'd255;
  localparam logic [LevelW-1:0]     LEVEL_MIN      = 8'd1;

  typedef struct packed {
    logic               pad_left;
    logic               pad_right;
    logic               pads_present;
    logic [TimeW-1:0]   now_ms;
    logic [FactorW-1:0] adapt_factor;
  } tpcp_in_t;

  typedef struct packed {
    logic               light_is_on;
    logic [EffectW-1:0] effect_mode;
    logic [LevelW-1:0]  level;
    logic               announce;
  } tpcp_out_t;

endpackage

`default_nettype wire

@@ hdl/tpcp_level_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpcp_level_calc (
  input  wire logic [tpcp_pkg::LevelW-1:0]  level,
  input  wire logic [tpcp_pkg::FactorW-1:0] factor,
  input  wire logic [tpcp_pkg::StepW-1:0]   step,
  output logic      [tpcp_pkg::LevelW-1:0]  level_down,
  output logic      [tpcp_pkg::LevelW-1:0]  level_up
);
  import tpcp_pkg::*;

  localparam int unsigned ProdW = LevelW + FactorW;

  logic [ProdW-1:0]  product;
  logic [ProdW:0]    div_sum;
  logic [LevelW-1:0] scaled;
  logic [LevelW-1:0] step_ext;
  logic [LevelW-1:0] up_limit;

  // floor(x / 255) = (x + (x >> 8) + 1) >> 8 for x up to 255 * 255
  assign product  = ProdW'(level) * ProdW'(factor);
  assign div_sum  = {1'b0, product} + (ProdW + 1)'(product >> 8) + (ProdW + 1)'(1);
  assign scaled   = div_sum[LevelW +: LevelW];
  assign step_ext = {1'b0, step};
  assign up_limit = LEVEL_MAX - step_ext;

  always_comb begin
    level_down = (scaled > step_ext) ? (scaled - step_ext) : LEVEL_MIN;
    level_up   = (scaled < up_limit) ? (scaled + step_ext) : LEVEL_MAX;
  end

endmodule

`default_nettype wire

@@ hdl/two_pad_touch_control_panel.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-pad touch panel decoder. One touch sample is taken per clock when the
// pipe flows; each sample gives exactly one result, presented on the output
// through the input register and then the result register that also updates
// the panel state, which holds while the output stalls; throughput is one
// sample per cycle while the output is not stalled.
// Both pads down toggles the light once; a single pad held for long_press_ms
// steps the brightness down (left) or up (right) from the level scaled by
// adapt_factor; a short release steps the effect backward (left) or forward
// (right). Samples with pads_present low change nothing. Write configuration
// only while no transaction is in flight.
module two_pad_touch_control_panel (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tpcp_pkg::tpcp_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tpcp_pkg::tpcp_out_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [tpcp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [tpcp_pkg::CfgDataW-1:0] cfg_wdata
);
  import tpcp_pkg::*;

  localparam logic [EffectW-1:0] EFFECT_NONE = 3'd0;
  localparam logic [EffectW-1:0] EFFECT_LAST = 3'd5;

  function automatic logic [EffectW-1:0] effect_fwd(input logic [EffectW-1:0] m);
    return (m >= EFFECT_LAST) ? EFFECT_NONE : m + EffectW'(1);
  endfunction

  function automatic logic [EffectW-1:0] effect_back(input logic [EffectW-1:0] m);
    return (m == EFFECT_NONE || m > EFFECT_LAST) ? EFFECT_LAST : m - EffectW'(1);
  endfunction

  logic [LongPressW-1:0] long_press_r;
  logic [StepW-1:0]      step_r;

  tpcp_in_t              in_r;
  logic                  in_valid_r;
  tpcp_out_t             out_r;
  logic                  out_valid_r;

  logic                  lheld_r, lheld_nxt;
  logic                  rheld_r, rheld_nxt;
  logic                  ldone_r, ldone_nxt;
  logic                  rdone_r, rdone_nxt;
  logic [TimeW-1:0]      lstart_r, lstart_nxt;
  logic [TimeW-1:0]      rstart_r, rstart_nxt;
  logic                  light_r, light_nxt;
  logic [EffectW-1:0]    effect_r, effect_nxt;
  logic [LevelW-1:0]     level_r, level_nxt;

  logic                  advance;
  logic [TimeW-1:0]      lelapsed;
  logic [TimeW-1:0]      relapsed;
  logic [LevelW-1:0]     level_down;
  logic [LevelW-1:0]     level_up;
  logic [EffectW-1:0]    effect_tmp;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign lelapsed = in_r.now_ms - lstart_r;
  assign relapsed = in_r.now_ms - rstart_r;

  tpcp_level_calc u_level_calc (
    .level      (level_r),
    .factor     (in_r.adapt_factor),
    .step       (step_r),
    .level_down (level_down),
    .level_up   (level_up)
  );

  always_comb begin
    lheld_nxt  = lheld_r;
    rheld_nxt  = rheld_r;
    ldone_nxt  = ldone_r;
    rdone_nxt  = rdone_r;
    lstart_nxt = lstart_r;
    rstart_nxt = rstart_r;
    light_nxt  = light_r;
    effect_nxt = effect_r;
    level_nxt  = level_r;
    effect_tmp = effect_r;
    if (advance && in_r.pads_present) begin
      if (in_r.pad_left && in_r.pad_right) begin
        if (!lheld_r && !rheld_r) begin
          light_nxt = !light_r;
        end
        lheld_nxt = 1'b1;
        rheld_nxt = 1'b1;
        ldone_nxt = 1'b1;
        rdone_nxt = 1'b1;
      end else if (in_r.pad_left) begin
        if (!lheld_r) begin
          lstart_nxt = in_r.now_ms;
          lheld_nxt  = 1'b1;
          ldone_nxt  = 1'b0;
        end else if (!ldone_r && (lelapsed >= TimeW'(long_press_r))) begin
          ldone_nxt = 1'b1;
          level_nxt = level_down;
        end
      end else if (in_r.pad_right) begin
        if (!rheld_r) begin
          rstart_nxt = in_r.now_ms;
          rheld_nxt  = 1'b1;
          rdone_nxt  = 1'b0;
        end else if (!rdone_r && (relapsed >= TimeW'(long_press_r))) begin
          rdone_nxt = 1'b1;
          level_nxt = level_up;
        end
      end else begin
        // apply left release first, then right
        if (lheld_r && !ldone_r) begin
          effect_tmp = effect_back(effect_tmp);
        end
        if (rheld_r && !rdone_r) begin
          effect_tmp = effect_fwd(effect_tmp);
        end
        effect_nxt = effect_tmp;
        lheld_nxt  = 1'b0;
        ldone_nxt  = 1'b0;
        rheld_nxt  = 1'b0;
        rdone_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      step_r       <= STEP_RST;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      lheld_r      <= 1'b0;
      rheld_r      <= 1'b0;
      ldone_r      <= 1'b0;
      rdone_r      <= 1'b0;
      lstart_r     <= '0;
      rstart_r     <= '0;
      light_r      <= 1'b1;
      effect_r     <= EFFECT_NONE;
      level_r      <= LEVEL_MAX;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LONG_PRESS_MS:   long_press_r <= cfg_wdata[LongPressW-1:0];
          CFG_BRIGHTNESS_STEP: step_r       <= cfg_wdata[StepW-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      lheld_r  <= lheld_nxt;
      rheld_r  <= rheld_nxt;
      ldone_r  <= ldone_nxt;
      rdone_r  <= rdone_nxt;
      lstart_r <= lstart_nxt;
      rstart_r <= rstart_nxt;
      light_r  <= light_nxt;
      effect_r <= effect_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r.light_is_on <= light_nxt;
      out_r.effect_mode <= effect_nxt;
      out_r.level       <= level_nxt;
      out_r.announce    <= (light_nxt != light_r) || (effect_nxt != effect_r) ||
                           (level_nxt != level_r);
    end
  end

  a_effect_range: assert property (@(posedge clk) disable iff (!rst_n)
    effect_r <= EFFECT_LAST)
    else $error("effect state out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed or dropped");

  a_left_done_held: assert property (@(posedge clk) disable iff (!rst_n)
    ldone_r |-> lheld_r)
    else $error("left long press without left held");

  a_right_done_held: assert property (@(posedge clk) disable iff (!rst_n)
    rdone_r |-> rheld_r)
    else $error("right long press without right held");

  a_absent_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_r.pads_present) |=>
      ($stable(light_r) && $stable(effect_r) && $stable(level_r) && !out_r.announce))
    else $error("absent sample changed panel state");

endmodule

`default_nettype wire
